>>> sv/md5rk_pkg.sv
// Package for the MD5 rolling-key XOR cipher: MD5 constants, helpers and shared types.
package md5rk_pkg;

   // MD5 chaining values at the start of a block
   localparam logic [31:0] MD5_IV_A = 32'h67452301;
   localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
   localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
   localparam logic [31:0] MD5_IV_D = 32'h10325476;

   // Rounds in one MD5 block
   localparam int unsigned MD5_ROUNDS = 64;
   localparam logic [5:0] MD5_LAST_ROUND = 6'(MD5_ROUNDS - 1);

   // Fixed words of the padded one-block message (4-byte key)
   localparam logic [3:0]  MSG_IDX_KEY = 4'd0;
   localparam logic [3:0]  MSG_IDX_PAD = 4'd1;
   localparam logic [3:0]  MSG_IDX_LEN = 4'd14;
   localparam logic [31:0] MSG_PAD_WORD = 32'h00000080;
   localparam logic [31:0] MSG_LEN_WORD = 32'd32;

   // Round constants
   localparam logic [31:0] MD5_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amounts, indexed by {phase, round[1:0]}
   localparam logic [4:0] MD5_ROT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word index used by a round
   function automatic logic [3:0] md5_msg_index(input logic [5:0] round);
      logic [3:0] r4;
      logic [3:0] idx;
      r4 = round[3:0];
      unique case (round[5:4])
         2'd0: idx = r4;
         2'd1: idx = 4'((r4 << 2) + r4 + 4'd1);
         2'd2: idx = 4'((r4 << 1) + r4 + 4'd5);
         2'd3: idx = 4'((r4 << 3) - r4);
      endcase
      return idx;
   endfunction

   // Status of the round unit toward the top level
   typedef struct packed {
      logic busy;
      logic done;
   } md5rk_status_type;

endpackage

>>> sv/md5_rolling_key_xor_cipher.sv
// Top level of the MD5 rolling-key XOR cipher: handshakes, key registers, output register.
//
//   channel   ports                                  direction
//   req       req_valid, req_stall, req_plain_word,  in
//             req_first_word
//   rsp       rsp_valid, rsp_stall, rsp_cipher_word  out
//   csr       csr_wr_en, csr_wr_data                 in
//
// Each word takes the transfer, 64 MD5 rounds in the shared round unit, and a
// final step that folds the digest word into the rolling key.
// The cipher word is registered at the transfer and waits there for the sink.
// A new word is taken once the key is updated and the output register is free.
// Synchronous reset clears initial_key and the rolling key to zero.
module md5_rolling_key_xor_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_plain_word,
   input  logic        req_first_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_cipher_word,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import md5rk_pkg::*;

   logic             busy_ff;
   logic             rsp_valid_ff;
   logic [31:0]      rsp_cipher_word_ff;
   logic [31:0]      initial_key_ff;
   logic [31:0]      rolling_key_ff;

   logic             req_accept;
   logic [31:0]      key_use;
   md5rk_status_type core_status;
   logic [31:0]      core_next_key;

   // Transfer control and key selection
   assign req_stall  = busy_ff | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign key_use    = req_first_word ? initial_key_ff : rolling_key_ff;

   md5rk_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .key      (key_use),
      .status   (core_status),
      .next_key (core_next_key)
   );

   // Busy flag, output register and keys
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         initial_key_ff <= 32'd0;
         rolling_key_ff <= 32'd0;
      end else begin
         if (csr_wr_en) begin
            initial_key_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_accept) begin
            busy_ff            <= 1'b1;
            rsp_valid_ff       <= 1'b1;
            rsp_cipher_word_ff <= req_plain_word ^ key_use;
         end else if (core_status.done) begin
            busy_ff        <= 1'b0;
            rolling_key_ff <= core_next_key;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_word = rsp_cipher_word_ff;

endmodule

>>> sv/md5rk_core.sv
// Iterative MD5 round unit: one round per cycle, returns key XOR digest word 3.
module md5rk_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              key,
   output md5rk_pkg::md5rk_status_type status,
   output logic [31:0]              next_key
);
   import md5rk_pkg::*;

   typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_type;

   state_type   state_ff;
   logic [5:0]  round_ff;
   logic        done_ff;
   logic [31:0] key_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] next_key_ff;

   logic [31:0] f_val;
   logic [3:0]  msg_idx;
   logic [31:0] msg_word;
   logic [31:0] sum;
   logic [4:0]  rot_amt;
   logic [63:0] rot_dbl;
   logic [31:0] b_in;

   // Round function, message word and the shared add/rotate datapath
   always_comb begin
      unique case (round_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         2'd3: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      msg_idx = md5_msg_index(round_ff);
      unique case (msg_idx)
         MSG_IDX_KEY: msg_word = key_ff;
         MSG_IDX_PAD: msg_word = MSG_PAD_WORD;
         MSG_IDX_LEN: msg_word = MSG_LEN_WORD;
         default:     msg_word = 32'd0;
      endcase
      sum     = a_ff + f_val + MD5_K[round_ff] + msg_word;
      rot_amt = MD5_ROT[{round_ff[5:4], round_ff[1:0]}];
      rot_dbl = {sum, sum} << rot_amt;
      b_in    = b_ff + rot_dbl[63:32];
   end

   // Sequencer and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= 6'd0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  key_ff   <= key;
                  a_ff     <= MD5_IV_A;
                  b_ff     <= MD5_IV_B;
                  c_ff     <= MD5_IV_C;
                  d_ff     <= MD5_IV_D;
                  round_ff <= 6'd0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               a_ff     <= d_ff;
               b_ff     <= b_in;
               c_ff     <= b_ff;
               d_ff     <= c_ff;
               round_ff <= round_ff + 6'd1;
               if (round_ff == MD5_LAST_ROUND) begin
                  // final d is the current c; add the IV and fold into the key
                  next_key_ff <= key_ff ^ (MD5_IV_D + c_ff);
                  done_ff     <= 1'b1;
                  state_ff    <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign status.busy = (state_ff == ST_RUN);
   assign status.done = done_ff;
   assign next_key    = next_key_ff;

endmodule
